/* hw/rtl/csvg_pkg.sv */
`default_nettype none
package csvg_pkg;

  localparam int SlcW = 9;
  localparam int IdxW = 8;
  localparam int VtxCnt = 12;
  localparam int VidxW = 4;
  localparam int OutDataW = 120;

  localparam logic [15:0] SinA = 16'd25736;
  localparam logic [15:0] SinB = 16'd10512;
  localparam logic [15:0] SinC = 16'd1160;
  localparam logic [15:0] QOne = 16'd16384;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegSlices = 2'd2;

  typedef struct packed {
    logic rim;
    logic top;
    logic nxt;
    logic last;
  } vmeta_t;

  // Vertex order: top j, top j+1, center top, bot j, bot j+1, center bot,
  // top j, bot j, bot j+1, top j, top j+1, bot j+1.
  localparam vmeta_t VtxTab [VtxCnt] = '{
    '{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b1}
  };

  typedef struct packed {
    logic       vld;
    vmeta_t     m;
    logic [16:0] qp;
    logic [16:0] qu;
    logic [8:0]  rp;
    logic [8:0]  ru;
  } dstg_t;

  typedef struct packed {
    logic       vld;
    vmeta_t     m;
    logic [15:0] u;
    logic       negs;
    logic       negc;
    logic [14:0] zs;
    logic [14:0] zc;
    logic [14:0] z2s;
    logic [14:0] z2c;
    logic [14:0] as;
    logic [14:0] ac;
  } tstg_t;

  function automatic logic [9:0] div_step(input logic [8:0] rem, input logic [8:0] n,
                                          input logic b);
    logic [9:0] t;
    logic [9:0] d;
    t = {rem, b};
    d = t - {1'b0, n};
    if (t >= {1'b0, n}) begin
      return {1'b1, d[8:0]};
    end
    return {1'b0, t[8:0]};
  endfunction

  function automatic logic [17:0] rnd14(input logic [31:0] x);
    logic [31:0] s;
    s = x + 32'd8192;
    return s[31:14];
  endfunction

  function automatic logic [14:0] fold_z(input logic [15:0] p);
    logic [15:0] r;
    logic [15:0] d;
    r = {2'b00, p[13:0]};
    d = QOne - r;
    return p[14] ? d[14:0] : r[14:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cylinder_slice_vertex_generator_core.sv */
`default_nettype none
// Each accepted slice beat yields twelve vertex beats, one per cycle while the
// output is not stalled; a new slice beat is taken while idle or in the cycle
// that issues the last vertex of the current slice. A vertex passes a sequencer,
// a nine-stage divider for phase and texture coordinate (the top quotient bit,
// then two bits per stage), five trig and scaling stages and an output register.
// Any output stall holds the whole pipeline in place.
module cylinder_slice_vertex_generator_core
  import csvg_pkg::*;
#(
  parameter int MAX_SLICES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // slice_index
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, zero fill
  output logic [OutDataW-1:0]      out_tdata,
  output logic                     out_tlast   // last_in_slice
);

  localparam logic [12:0] MaxS = 13'(MAX_SLICES);
  localparam int DivN = 8;

  logic [14:0] radius_r;
  logic [15:0] height_r;
  logic [8:0]  slices_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 15'd256;
      height_r <= 16'd512;
      slices_r <= 9'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegRadius: radius_r <= cfg_wdata[14:0];
        RegHeight: height_r <= cfg_wdata;
        RegSlices: slices_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0] n_c;
  logic [8:0] n_m1;
  always_comb begin
    if (slices_r == 9'd0) n_c = 9'd1;
    else if ({4'b0, slices_r} > MaxS) n_c = MaxS[8:0];
    else n_c = slices_r;
    n_m1 = n_c - 9'd1;
  end

  logic [15:0] lo_p;
  logic [15:0] lo_u;
  assign lo_p = {8'b0, n_c[8:1]};
  assign lo_u = {7'b0, n_c[8:1], 1'b0};

  logic adv;
  logic out_vld_r;
  assign adv = !out_vld_r || out_tready;

  logic             busy_r;
  logic [VidxW-1:0] vidx_r;
  logic [7:0]       j_r;
  logic             issue;
  logic             last_issue;
  logic             in_acc;
  logic [7:0]       j_sat;

  assign issue = busy_r && adv;
  assign last_issue = issue && (vidx_r == 4'(VtxCnt - 1));
  assign in_tready = !busy_r || last_issue;
  assign in_acc = in_tvalid && in_tready;
  assign j_sat = ({1'b0, in_tdata} > n_m1) ? n_m1[7:0] : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vidx_r <= '0;
      j_r    <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      vidx_r <= '0;
      j_r    <= j_sat;
    end else if (last_issue) begin
      busy_r <= 1'b0;
    end else if (issue) begin
      vidx_r <= vidx_r + 4'd1;
    end
  end

  dstg_t d_r [DivN+1];
  dstg_t d_nxt [DivN+1];

  always_comb begin
    vmeta_t     m;
    logic [8:0] k;
    logic       qt;
    logic [8:0] r0;
    m = VtxTab[vidx_r];
    k = {1'b0, j_r} + {8'b0, m.rim & m.nxt};
    qt = (k >= n_c);
    r0 = qt ? (k - n_c) : k;
    d_nxt[0] = '{vld: issue, m: m, qp: {16'b0, qt}, qu: {16'b0, qt}, rp: r0, ru: r0};
  end

  for (genvar s = 1; s <= DivN; s++) begin : g_div
    always_comb begin
      logic [9:0] p1;
      logic [9:0] p2;
      logic [9:0] u1;
      logic [9:0] u2;
      p1 = div_step(d_r[s-1].rp, n_c, lo_p[17-2*s]);
      p2 = div_step(p1[8:0], n_c, lo_p[16-2*s]);
      u1 = div_step(d_r[s-1].ru, n_c, lo_u[17-2*s]);
      u2 = div_step(u1[8:0], n_c, lo_u[16-2*s]);
      d_nxt[s].vld = d_r[s-1].vld;
      d_nxt[s].m   = d_r[s-1].m;
      d_nxt[s].qp  = {d_r[s-1].qp[14:0], p1[9], p2[9]};
      d_nxt[s].qu  = {d_r[s-1].qu[14:0], u1[9], u2[9]};
      d_nxt[s].rp  = p2[8:0];
      d_nxt[s].ru  = u2[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DivN; i++) d_r[i] <= '0;
    end else if (adv) begin
      for (int i = 0; i <= DivN; i++) d_r[i] <= d_nxt[i];
    end
  end

  tstg_t t1_r, t2_r, t3_r, t4_r;
  tstg_t t1_nxt, t2_nxt, t3_nxt, t4_nxt;
  logic [15:0] pm_s_r, pm_c_r;
  logic [15:0] pm_s_nxt, pm_c_nxt;
  tstg_t t5_r;

  always_comb begin
    logic [15:0] p;
    logic [15:0] pc;
    logic [17:0] a;
    logic [17:0] b;
    p = d_r[DivN].qp[15:0];
    pc = p + QOne;
    t1_nxt = '0;
    t1_nxt.vld  = d_r[DivN].vld;
    t1_nxt.m    = d_r[DivN].m;
    t1_nxt.u    = d_r[DivN].qu[16:1];
    t1_nxt.negs = p[15];
    t1_nxt.negc = pc[15];
    t1_nxt.zs   = fold_z(p);
    t1_nxt.zc   = fold_z(pc);
    a = rnd14({17'b0, t1_nxt.zs} * {17'b0, t1_nxt.zs});
    b = rnd14({17'b0, t1_nxt.zc} * {17'b0, t1_nxt.zc});
    t1_nxt.z2s  = a[14:0];
    t1_nxt.z2c  = b[14:0];
  end

  always_comb begin
    logic [17:0] a;
    logic [17:0] b;
    logic [15:0] ta;
    logic [15:0] tb;
    t2_nxt = t1_r;
    a = rnd14({17'b0, t1_r.z2s} * {16'b0, SinC});
    b = rnd14({17'b0, t1_r.z2c} * {16'b0, SinC});
    ta = SinB - a[15:0];
    tb = SinB - b[15:0];
    t2_nxt.as = ta[14:0];
    t2_nxt.ac = tb[14:0];
  end

  always_comb begin
    logic [17:0] a;
    logic [17:0] b;
    logic [15:0] ua;
    logic [15:0] ub;
    t3_nxt = t2_r;
    a = rnd14({17'b0, t2_r.z2s} * {17'b0, t2_r.as});
    b = rnd14({17'b0, t2_r.z2c} * {17'b0, t2_r.ac});
    ua = SinA - a[15:0];
    ub = SinA - b[15:0];
    t3_nxt.as = ua[14:0];
    t3_nxt.ac = ub[14:0];
  end

  always_comb begin
    logic [17:0] a;
    logic [17:0] b;
    t4_nxt = t3_r;
    a = rnd14({17'b0, t3_r.zs} * {17'b0, t3_r.as});
    b = rnd14({17'b0, t3_r.zc} * {17'b0, t3_r.ac});
    t4_nxt.as = a[14:0];
    t4_nxt.ac = b[14:0];
  end

  always_comb begin
    logic [17:0] a;
    logic [17:0] b;
    a = rnd14({17'b0, t4_r.as} * {17'b0, radius_r});
    b = rnd14({17'b0, t4_r.ac} * {17'b0, radius_r});
    pm_s_nxt = a[15:0];
    pm_c_nxt = b[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
      t5_r <= '0;
    end else if (adv) begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
      t4_r <= t4_nxt;
      t5_r <= t4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_s_r <= pm_s_nxt;
      pm_c_r <= pm_c_nxt;
    end
  end

  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] out_data_nxt;
  logic                out_last_r;

  always_comb begin
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] half;
    logic [15:0] sm;
    logic [15:0] cm;
    logic [15:0] tv;
    half = {1'b0, height_r[15:1]};
    sm = {1'b0, t5_r.as};
    cm = {1'b0, t5_r.ac};
    px = '0;
    py = '0;
    nx = '0;
    ny = '0;
    if (t5_r.m.rim) begin
      nx = t5_r.negc ? -cm : cm;
      ny = t5_r.negs ? -sm : sm;
      px = t5_r.negc ? -pm_c_r : pm_c_r;
      py = t5_r.negs ? -pm_s_r : pm_s_r;
    end
    pz = t5_r.m.top ? -half : half;
    tv = 16'd32768 - t5_r.u;
    out_data_nxt = {7'b0, tv, t5_r.u, 1'b0, ny, nx, pz, py, px};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= t5_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= t5_r.m.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule
`default_nettype wire

/* tb/sv/cylinder_slice_vertex_generator_core_test.sv */
`default_nettype none
module cylinder_slice_vertex_generator_core_test
  import csvg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic        nz;
    logic [15:0] tu;
    logic [15:0] tv;
    logic        last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic out_tlast;

  cylinder_slice_vertex_generator_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int unsigned cur_radius;
  int unsigned cur_height;
  int unsigned cur_slices;
  logic [7:0] slice_queue[$];
  vertex_t expected_vertices[$];
  int err_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_phase = 0;

  function automatic int unsigned round14(input longint unsigned x);
    return int'((x + 8192) >> 14);
  endfunction

  function automatic int unsigned sine_mag(input int unsigned z);
    int unsigned z2;
    int unsigned t;
    int unsigned u;
    z2 = round14(z * z);
    t = int'(SinB) - round14(z2 * int'(SinC));
    u = int'(SinA) - round14(longint'(z2) * t);
    return round14(longint'(z) * u);
  endfunction

  // Sine of a 16-bit full-circle phase; returns magnitude, sets neg.
  function automatic int unsigned phase_sine(input int unsigned p, output bit neg);
    int unsigned q;
    int unsigned r;
    q = (p >> 14) & 3;
    r = p & 16'h3FFF;
    neg = q[1];
    return sine_mag(q[0] ? 16384 - r : r);
  endfunction

  task automatic predict_slice(input logic [7:0] idx);
    int unsigned n;
    int unsigned j;
    int unsigned k;
    int unsigned p;
    int unsigned u;
    int unsigned cm;
    int unsigned sm;
    bit cneg;
    bit sneg;
    vertex_t v;
    n = cur_slices == 0 ? 1 : (cur_slices > 256 ? 256 : cur_slices);
    j = idx > n - 1 ? n - 1 : idx;
    for (int i = 0; i < VtxCnt; i++) begin
      k = j + (VtxTab[i].rim ? VtxTab[i].nxt : 0);
      p = ((k * 65536 + n / 2) / n) & 16'hFFFF;
      u = (k * 32768 + n / 2) / n;
      v.px = '0;
      v.py = '0;
      v.nx = '0;
      v.ny = '0;
      v.pz = VtxTab[i].top ? -16'(cur_height >> 1) : 16'(cur_height >> 1);
      if (VtxTab[i].rim) begin
        cm = phase_sine((p + 16384) & 16'hFFFF, cneg);
        sm = phase_sine(p, sneg);
        v.nx = cneg ? -16'(cm) : 16'(cm);
        v.ny = sneg ? -16'(sm) : 16'(sm);
        v.px = cneg ? -16'(round14(cm * cur_radius)) : 16'(round14(cm * cur_radius));
        v.py = sneg ? -16'(round14(sm * cur_radius)) : 16'(round14(sm * cur_radius));
      end
      v.nz = 1'b0;
      v.tu = 16'(u);
      v.tv = 16'(32768 - u);
      v.last = (i == VtxCnt - 1);
      expected_vertices = {expected_vertices, v};
    end
  endtask

  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      predict_slice(in_tdata);
    end
    if (!rst_n || (in_tvalid && !in_tready)) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (slice_queue.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= slice_queue.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    vertex_t a;
    if (out_tvalid && out_tready) begin
      a.px = out_tdata[15:0];
      a.py = out_tdata[31:16];
      a.pz = out_tdata[47:32];
      a.nx = out_tdata[63:48];
      a.ny = out_tdata[79:64];
      a.nz = out_tdata[80];
      a.tu = out_tdata[96:81];
      a.tv = out_tdata[112:97];
      a.last = out_tlast;
      if (expected_vertices.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected vertex beat %p", a);
      end else begin
        e = expected_vertices.pop_front();
        if (a != e) begin
          err_count++;
          if (err_count <= 10) $display("mismatch: expected %p actual %p", e, a);
        end
      end
    end
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 64) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (stall_phase % 7) < 4;
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic write_reg(input logic [1:0] addr, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= 16'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == RegRadius) cur_radius = value & 16'h7FFF;
    else if (addr == RegHeight) cur_height = value & 16'hFFFF;
    else if (addr == RegSlices) cur_slices = value & 9'h1FF;
  endtask

  task automatic drain;
    wait (slice_queue.size() == 0 && !in_tvalid);
    @(posedge clk);
    wait (expected_vertices.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned slices);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) slice_queue = {slice_queue, 8'($urandom)};
      else slice_queue = {slice_queue, 8'($urandom_range(0, slices == 0 ? 0 : slices - 1))};
    end
    drain();
  endtask

  initial begin
    cur_radius = 256;
    cur_height = 512;
    cur_slices = 32;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 32; i += 5) slice_queue = {slice_queue, 8'(i)};
    slice_queue = {slice_queue, 8'd31};
    slice_queue = {slice_queue, 8'd255};
    drain();
    write_reg(RegRadius, 32767);
    write_reg(RegHeight, 65535);
    write_reg(RegSlices, 256);
    slice_queue = {slice_queue, 8'd0};
    slice_queue = {slice_queue, 8'd64};
    slice_queue = {slice_queue, 8'd128};
    slice_queue = {slice_queue, 8'd192};
    slice_queue = {slice_queue, 8'd255};
    drain();
    write_reg(RegRadius, 0);
    write_reg(RegHeight, 0);
    write_reg(RegSlices, 1);
    slice_queue = {slice_queue, 8'd0};
    slice_queue = {slice_queue, 8'd170};
    drain();
    write_reg(RegSlices, 0);
    write_reg(RegHeight, 1);
    write_reg(RegUnused, 16'hFFFF);
    slice_queue = {slice_queue, 8'd85};
    drain();
    write_reg(RegSlices, 511);
    write_reg(RegRadius, 16'h8000 | 1000);
    run_phase(5, 256);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegRadius, $urandom_range(0, 32767));
      write_reg(RegHeight, $urandom_range(0, 65535));
      write_reg(RegSlices, ph == 0 ? 3 : $urandom_range(1, 256));
      run_phase(26, cur_slices);
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
